>>> rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared widths, item kinds, status codes and the control bundle that the
// sequencer hands to the deadline unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

	localparam int NUM_TASKS_DEF = 8;
	localparam int KIND_W        = 2;
	localparam int SLOT_OUT_W    = 3;
	localparam int TICK_W        = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_DELAY  = 2'd2,
		KIND_SWITCH = 2'd3
	} kind_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Requests from the sequencer to the deadline unit.
	typedef struct packed {
		logic rd_en;   // read the entry at the slot address
		logic wr_en;   // write the entry at the slot address
		logic wr_zero; // write zero instead of the adder result
		logic inc;     // adder operand is one instead of the delay
	} dl_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/rrts_dl_unit.sv
// ----------------------------------------------------------------------------
// Deadline unit
// Holds the per-slot deadline memory and the one shared adder and comparator
// that serve tick increment, deadline computation and deadline checks.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dl_unit
	import rrts_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF,
	localparam int IDX_W = $clog2(NUM_TASKS)
) (
	input  wire logic              clk,
	input  wire dl_ctl_t           ctl,
	input  wire logic [IDX_W-1:0]  addr,
	input  wire logic [TICK_W-1:0] tick,
	input  wire logic [TICK_W-1:0] delay,
	output logic      [TICK_W-1:0] sum,
	output logic                   le
);

	logic [TICK_W-1:0] mem [NUM_TASKS];
	logic [TICK_W-1:0] rd_data_q;
	logic [TICK_W-1:0] operand;

	// The shared adder: tick plus one, or tick plus the requested delay.
	assign operand = ctl.inc ? TICK_W'(1) : delay;
	assign sum     = tick + operand;

	// The shared comparator checks the last entry read against the tick.
	assign le = (rd_data_q <= tick);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= ctl.wr_zero ? '0 : sum;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Task table with a tick counter, tick-based blocking and a round-robin pick
// of the next ready task; slot 0 is the idle task.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                        Handshake
// -------   ------------------------------------------   ----------------------
// command   kind, delay_ticks                            start high, busy low
// result    running_task, status, added_slot, tick_now   done strobe, one cycle
//
// Command steps: tick increments the tick and, unless only the idle task is
// used, reads slots 1 to the last used one, one slot per cycle, through the
// deadline memory's read port and the shared comparator, then drains the last
// compare; add zeroes a free slot's deadline; delay stores tick plus delay as
// the deadline of a non-idle current task, blocks it and picks; switch picks.
// A new command may be accepted in the cycle the done strobe is high.
// Reset leaves only the idle task present and ready, current slot 0 and the
// tick at zero; the deadline memory is not cleared. The receiver cannot stall.
//
`default_nettype none

module round_robin_task_scheduler
	import rrts_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [TICK_W-1:0]     delay_ticks,
	output logic                       done,
	output logic      [SLOT_OUT_W-1:0] running_task,
	output logic                       status,
	output logic      [SLOT_OUT_W-1:0] added_slot,
	output logic      [TICK_W-1:0]     tick_now
);

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_INC,
		ST_TICK_SCAN,
		ST_TICK_DRAIN,
		ST_ADD,
		ST_DELAY,
		ST_PICK,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [TICK_W-1:0]    tick_q;
	logic [IDX_W-1:0]     current_q;
	logic [CNT_W-1:0]     used_q;
	logic [NUM_TASKS-1:0] ready_q;
	logic [TICK_W-1:0]    delay_q;
	logic                 status_q;
	logic [IDX_W-1:0]     added_q;
	logic [IDX_W-1:0]     idx_q;      // scan address, also the pick position
	logic [IDX_W-1:0]     cnt_q;      // pick steps taken
	logic                 cmp_vld_q;  // a deadline read is waiting for compare
	logic [IDX_W-1:0]     cmp_idx_q;  // slot of that read
	logic                 done_q;
	logic [SLOT_OUT_W-1:0] running_q;
	logic                 status_out_q;
	logic [SLOT_OUT_W-1:0] added_out_q;
	logic [TICK_W-1:0]    tick_out_q;

	dl_ctl_t              dl_ctl;
	logic [IDX_W-1:0]     dl_addr;
	logic [TICK_W-1:0]    dl_sum;
	logic                 dl_le;

	logic                 table_full;
	logic [IDX_W-1:0]     free_slot;
	logic [IDX_W-1:0]     last_slot;
	logic [IDX_W-1:0]     pick_nxt;
	logic                 pick_hit;
	logic [IDX_W+SLOT_OUT_W-1:0] cur_ext;
	logic [IDX_W+SLOT_OUT_W-1:0] added_ext;

	// The used count never exceeds the table size, so the next free slot and
	// the last used slot both fit an index.
	assign table_full = (used_q >= CNT_W'(NUM_TASKS));
	assign free_slot  = used_q[IDX_W-1:0];
	assign last_slot  = IDX_W'(used_q - CNT_W'(1));

	// One round-robin step past the pick position; slot 0 never counts as a hit.
	assign pick_nxt = (idx_q == IDX_W'(NUM_TASKS - 1)) ? '0 : idx_q + IDX_W'(1);
	assign pick_hit = (pick_nxt != '0) && ready_q[pick_nxt];

	assign cur_ext   = {{SLOT_OUT_W{1'b0}}, current_q};
	assign added_ext = {{SLOT_OUT_W{1'b0}}, added_q};

	// Requests to the deadline unit for the current step.
	always_comb begin
		dl_ctl  = '0;
		dl_addr = idx_q;
		case (state_q)
			ST_TICK_INC: begin
				dl_ctl.inc = 1'b1;
			end
			ST_TICK_SCAN: begin
				dl_ctl.rd_en = 1'b1;
			end
			ST_ADD: begin
				dl_ctl.wr_en   = !table_full;
				dl_ctl.wr_zero = 1'b1;
				dl_addr        = free_slot;
			end
			ST_DELAY: begin
				dl_ctl.wr_en = (current_q != '0);
				dl_addr      = current_q;
			end
			default: begin
				dl_ctl = '0;
			end
		endcase
	end

	rrts_dl_unit #(
		.NUM_TASKS(NUM_TASKS)
	) u_dl_unit (
		.clk  (clk),
		.ctl  (dl_ctl),
		.addr (dl_addr),
		.tick (tick_q),
		.delay(delay_q),
		.sum  (dl_sum),
		.le   (dl_le)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			current_q    <= '0;
			used_q       <= CNT_W'(1);
			ready_q      <= NUM_TASKS'(1);
			delay_q      <= '0;
			status_q     <= STATUS_OK;
			added_q      <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			cmp_vld_q    <= 1'b0;
			cmp_idx_q    <= '0;
			done_q       <= 1'b0;
			running_q    <= '0;
			status_out_q <= STATUS_OK;
			added_out_q  <= '0;
			tick_out_q   <= '0;
		end else begin
			// The result strobe follows the finishing cycle.
			done_q <= (state_q == ST_FINISH);

			// A deadline read from the previous cycle is checked here; only
			// blocked tasks whose deadline has come are released.
			if (cmp_vld_q && dl_le && !ready_q[cmp_idx_q]) begin
				ready_q[cmp_idx_q] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						status_q <= STATUS_OK;
						added_q  <= '0;
						delay_q  <= delay_ticks;
						idx_q    <= current_q;
						cnt_q    <= '0;
						case (kind_t'(kind))
							KIND_TICK:   state_q <= ST_TICK_INC;
							KIND_ADD:    state_q <= ST_ADD;
							KIND_DELAY:  state_q <= ST_DELAY;
							KIND_SWITCH: state_q <= ST_PICK;
							default:     state_q <= ST_FINISH;
						endcase
					end
				end

				ST_TICK_INC: begin
					tick_q    <= dl_sum;
					idx_q     <= IDX_W'(1);
					cmp_vld_q <= 1'b0;
					state_q   <= (used_q == CNT_W'(1)) ? ST_FINISH : ST_TICK_SCAN;
				end

				// Reads go out one slot per cycle; each is compared in the cycle after it.
				ST_TICK_SCAN: begin
					cmp_vld_q <= 1'b1;
					cmp_idx_q <= idx_q;
					if (idx_q == last_slot) begin
						state_q <= ST_TICK_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end

				ST_TICK_DRAIN: begin
					cmp_vld_q <= 1'b0;
					state_q   <= ST_FINISH;
				end

				ST_ADD: begin
					if (table_full) begin
						status_q <= STATUS_FULL;
					end else begin
						added_q            <= free_slot;
						ready_q[free_slot] <= 1'b1;
						used_q             <= used_q + CNT_W'(1);
					end
					state_q <= ST_FINISH;
				end

				// The idle task cannot block, and then no new pick is made.
				ST_DELAY: begin
					if (current_q != '0) begin
						ready_q[current_q] <= 1'b0;
						state_q            <= ST_PICK;
					end else begin
						state_q <= ST_FINISH;
					end
				end

				// Walk once around the table from the slot after the current one;
				// the idle task runs when no slot but slot 0 is ready.
				ST_PICK: begin
					if (pick_hit) begin
						current_q <= pick_nxt;
						state_q   <= ST_FINISH;
					end else if (cnt_q == IDX_W'(NUM_TASKS - 1)) begin
						current_q <= '0;
						state_q   <= ST_FINISH;
					end else begin
						idx_q <= pick_nxt;
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end

				ST_FINISH: begin
					running_q    <= cur_ext[SLOT_OUT_W-1:0];
					status_out_q <= status_q;
					added_out_q  <= added_ext[SLOT_OUT_W-1:0];
					tick_out_q   <= tick_q;
					state_q      <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign running_task = running_q;
	assign status       = status_out_q;
	assign added_slot   = added_out_q;
	assign tick_now     = tick_out_q;

endmodule

`default_nettype wire

>>> rtl/core/rrts_checker.sv
// ----------------------------------------------------------------------------
// Round-robin task scheduler checker
// Port-level checks on the command and result transfers, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_checker
	import rrts_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic                  status,
	input wire logic [SLOT_OUT_W-1:0] added_slot
);

	// An accepted command keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer did not make the block busy");

	// A result is only shown once the block has finished its command.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the block is busy");

	// Each result transfer lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// A full table never hands out a slot.
	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_FULL) |-> (added_slot == '0))
		else $error("slot reported together with table full");

	// A result with a slot handed out was a successful add, so status is ok.
	a_added_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (added_slot != '0) |-> (status == STATUS_OK))
		else $error("added slot reported with a failing status");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.added_slot  (added_slot)
);

`default_nettype wire
